/* src/dvtu_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package dvtu_pkg;

    localparam int ADDR_W     = 5;
    localparam int DATA_W     = 32;
    localparam int IFACE_REGS = 4;

    localparam logic [2:0] REG_OWN_IFACE_0     = 3'd0;
    localparam logic [2:0] REG_OWN_IFACE_1     = 3'd1;
    localparam logic [2:0] REG_OWN_IFACE_2     = 3'd2;
    localparam logic [2:0] REG_OWN_IFACE_3     = 3'd3;
    localparam logic [2:0] REG_OWN_IFACE_COUNT = 3'd4;

    localparam logic [2:0] ACT_APPENDED = 3'd0;
    localparam logic [2:0] ACT_UPDATED  = 3'd1;
    localparam logic [2:0] ACT_KEPT     = 3'd2;
    localparam logic [2:0] ACT_REJECTED = 3'd3;
    localparam logic [2:0] ACT_FULL     = 3'd4;

    localparam logic OP_INSTALL = 1'b1;

    localparam logic [7:0] COST_MAX = 8'hFF;

    typedef struct packed {
        logic        operation;
        logic        msg_start;
        logic [31:0] dest_addr;
        logic [7:0]  adv_cost;
        logic [31:0] adv_next_hop;
        logic [31:0] sender_addr;
        logic [31:0] recv_iface;
    } route_word_t;

    typedef struct packed {
        logic [2:0] action;
        logic [3:0] entry_index;
        logic [7:0] entry_cost;
        logic [4:0] entry_count;
    } result_word_t;

    typedef struct packed {
        logic [31:0] dest;
        logic [31:0] next_hop;
        logic [31:0] iface;
        logic [7:0]  cost;
    } route_entry_t;

    typedef struct packed {
        logic [IFACE_REGS-1:0][31:0] own_iface;
        logic [2:0]                  own_iface_count;
    } cfg_t;

endpackage

`default_nettype wire

/* src/dvtu_regs.sv */
`timescale 1ns / 1ps
`default_nettype none

module dvtu_regs
    import dvtu_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    logic [IFACE_REGS-1:0][31:0] own_iface_reg;
    logic [IFACE_REGS-1:0][31:0] own_iface_next;
    logic [2:0]                  count_reg;
    logic [2:0]                  count_next;
    logic [2:0]                  reg_sel;
    logic                        wr_en;

    assign reg_sel = paddr[ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_comb
    begin
        own_iface_next = own_iface_reg;
        count_next     = count_reg;
        if (wr_en)
        begin
            unique case (reg_sel)
                REG_OWN_IFACE_0:     own_iface_next[0] = pwdata;
                REG_OWN_IFACE_1:     own_iface_next[1] = pwdata;
                REG_OWN_IFACE_2:     own_iface_next[2] = pwdata;
                REG_OWN_IFACE_3:     own_iface_next[3] = pwdata;
                REG_OWN_IFACE_COUNT: count_next = pwdata[2:0];
                default:             count_next = count_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_iface_reg <= '0;
            count_reg     <= '0;
        end
        else
        begin
            own_iface_reg <= own_iface_next;
            count_reg     <= count_next;
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_OWN_IFACE_0:     prdata = own_iface_reg[0];
            REG_OWN_IFACE_1:     prdata = own_iface_reg[1];
            REG_OWN_IFACE_2:     prdata = own_iface_reg[2];
            REG_OWN_IFACE_3:     prdata = own_iface_reg[3];
            REG_OWN_IFACE_COUNT: prdata = {{(DATA_W-3){1'b0}}, count_reg};
            default:             prdata = '0;
        endcase
    end

    assign cfg = '{own_iface: own_iface_reg, own_iface_count: count_reg};

endmodule

`default_nettype wire

/* src/dvtu_table.sv */
`timescale 1ns / 1ps
`default_nettype none

module dvtu_table
    import dvtu_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int IDX_W = 4
)
(
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [IDX_W-1:0] waddr,
    input  wire route_entry_t     wdata,
    input  wire logic             re,
    input  wire logic [IDX_W-1:0] raddr,
    output route_entry_t          rdata
);

    route_entry_t mem [DEPTH];
    route_entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* src/dvtu_engine.sv */
`timescale 1ns / 1ps
`default_nettype none

module dvtu_engine
    import dvtu_pkg::*;
#(
    parameter int TABLE_DEPTH    = 16,
    parameter int MAX_OWN_IFACES = 4,
    parameter int IDX_W          = 4,
    parameter int CNT_W          = 5
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire cfg_t             cfg,
    input  wire logic             route_valid,
    output logic                  route_stall,
    input  wire route_word_t      route,
    output logic                  result_valid,
    input  wire logic             result_stall,
    output result_word_t          result,
    output logic                  tbl_we,
    output logic      [IDX_W-1:0] tbl_waddr,
    output route_entry_t          tbl_wdata,
    output logic                  tbl_re,
    output logic      [IDX_W-1:0] tbl_raddr,
    input  wire route_entry_t     tbl_rdata
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]       state_reg, state_next;
    route_word_t      item_reg, item_next;
    logic [CNT_W-1:0] valid_count_reg, valid_count_next;
    logic [CNT_W-1:0] snap_reg, snap_next;
    logic [CNT_W-1:0] limit_reg, limit_next;
    logic [CNT_W-1:0] issue_idx_reg, issue_idx_next;
    logic             pend_reg, pend_next;
    logic [IDX_W-1:0] pend_idx_reg, pend_idx_next;
    logic             found_reg, found_next;
    logic [IDX_W-1:0] first_idx_reg, first_idx_next;
    logic [7:0]       first_cost_reg, first_cost_next;
    logic [7:0]       new_cost_reg, new_cost_next;
    logic [31:0]      new_hop_reg, new_hop_next;
    logic             self_hop_reg, self_hop_next;
    logic [31:0]      wr_dest_reg, wr_dest_next;
    logic [2:0]       res_action_reg, res_action_next;
    logic [IDX_W-1:0] res_idx_reg, res_idx_next;
    logic [7:0]       res_cost_reg, res_cost_next;
    logic             res_write_reg, res_write_next;
    logic             res_append_reg, res_append_next;
    logic             result_valid_reg, result_valid_next;
    result_word_t     result_reg, result_next;

    logic [CNT_W-1:0] snap_now;
    logic [CNT_W-1:0] count_after;
    logic [2:0]       iface_limit;
    logic             own_hit;
    logic             issue_more;
    logic             hit;

    // Own-interface check on the advertised next hop, done once at accept.
    always_comb
    begin
        if (cfg.own_iface_count > 3'(MAX_OWN_IFACES))
        begin
            iface_limit = 3'(MAX_OWN_IFACES);
        end
        else
        begin
            iface_limit = cfg.own_iface_count;
        end
        own_hit = 1'b0;
        for (int k = 0; k < IFACE_REGS; k++)
        begin
            if ((3'(k) < iface_limit) && (cfg.own_iface[k] == route.adv_next_hop))
            begin
                own_hit = 1'b1;
            end
        end
    end

    assign snap_now    = route.msg_start ? valid_count_reg : snap_reg;
    assign issue_more  = issue_idx_reg < limit_reg;
    assign hit         = pend_reg && (tbl_rdata.dest == item_reg.dest_addr);
    assign count_after = valid_count_reg + {{(CNT_W-1){1'b0}}, res_append_reg};

    always_comb
    begin
        state_next        = state_reg;
        item_next         = item_reg;
        valid_count_next  = valid_count_reg;
        snap_next         = snap_reg;
        limit_next        = limit_reg;
        issue_idx_next    = issue_idx_reg;
        pend_next         = pend_reg;
        pend_idx_next     = pend_idx_reg;
        found_next        = found_reg;
        first_idx_next    = first_idx_reg;
        first_cost_next   = first_cost_reg;
        new_cost_next     = new_cost_reg;
        new_hop_next      = new_hop_reg;
        self_hop_next     = self_hop_reg;
        wr_dest_next      = wr_dest_reg;
        res_action_next   = res_action_reg;
        res_idx_next      = res_idx_reg;
        res_cost_next     = res_cost_reg;
        res_write_next    = res_write_reg;
        res_append_next   = res_append_reg;
        result_valid_next = result_valid_reg;
        result_next       = result_reg;
        tbl_re            = 1'b0;
        tbl_we            = 1'b0;

        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (route_valid)
                begin
                    item_next      = route;
                    snap_next      = snap_now;
                    issue_idx_next = '0;
                    pend_next      = 1'b0;
                    found_next     = 1'b0;
                    self_hop_next  = own_hit;
                    if (route.operation == OP_INSTALL)
                    begin
                        limit_next    = '0;
                        new_cost_next = route.adv_cost;
                        new_hop_next  = route.adv_next_hop;
                    end
                    else
                    begin
                        limit_next    = (snap_now < valid_count_reg) ? snap_now
                                                                     : valid_count_reg;
                        new_cost_next = (route.adv_cost == COST_MAX) ? COST_MAX
                                                                     : route.adv_cost + 8'd1;
                        new_hop_next  = route.sender_addr;
                    end
                    state_next = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                // Reads run one entry ahead of the compare stage.
                if (issue_more)
                begin
                    tbl_re         = 1'b1;
                    pend_next      = 1'b1;
                    pend_idx_next  = issue_idx_reg[IDX_W-1:0];
                    issue_idx_next = issue_idx_reg + {{(CNT_W-1){1'b0}}, 1'b1};
                end
                else
                begin
                    pend_next = 1'b0;
                end

                priority if (hit && (new_cost_reg < tbl_rdata.cost))
                begin
                    pend_next       = 1'b0;
                    res_idx_next    = pend_idx_reg;
                    wr_dest_next    = tbl_rdata.dest;
                    res_append_next = 1'b0;
                    if (self_hop_reg)
                    begin
                        res_action_next = ACT_REJECTED;
                        res_cost_next   = tbl_rdata.cost;
                        res_write_next  = 1'b0;
                    end
                    else
                    begin
                        res_action_next = ACT_UPDATED;
                        res_cost_next   = new_cost_reg;
                        res_write_next  = 1'b1;
                    end
                    state_next = ST_EMIT;
                end
                else if (!pend_reg && !issue_more)
                begin
                    if (found_reg)
                    begin
                        res_action_next = ACT_KEPT;
                        res_idx_next    = first_idx_reg;
                        res_cost_next   = first_cost_reg;
                        res_write_next  = 1'b0;
                        res_append_next = 1'b0;
                    end
                    else if (valid_count_reg >= CNT_W'(TABLE_DEPTH))
                    begin
                        res_action_next = ACT_FULL;
                        res_idx_next    = '0;
                        res_cost_next   = '0;
                        res_write_next  = 1'b0;
                        res_append_next = 1'b0;
                    end
                    else
                    begin
                        res_action_next = ACT_APPENDED;
                        res_idx_next    = valid_count_reg[IDX_W-1:0];
                        res_cost_next   = new_cost_reg;
                        res_write_next  = 1'b1;
                        res_append_next = 1'b1;
                        wr_dest_next    = item_reg.dest_addr;
                    end
                    state_next = ST_EMIT;
                end
                else if (hit && !found_reg)
                begin
                    found_next      = 1'b1;
                    first_idx_next  = pend_idx_reg;
                    first_cost_next = tbl_rdata.cost;
                end
                else
                begin
                    found_next = found_reg;
                end
            end

            ST_EMIT:
            begin
                // The table write and the count change wait for the output slot.
                if (!result_valid_reg || !result_stall)
                begin
                    tbl_we                  = res_write_reg;
                    valid_count_next        = count_after;
                    result_valid_next       = 1'b1;
                    result_next.action      = res_action_reg;
                    result_next.entry_index = 4'(res_idx_reg);
                    result_next.entry_cost  = res_cost_reg;
                    result_next.entry_count = 5'(count_after);
                    state_next              = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            valid_count_reg  <= '0;
            snap_reg         <= '0;
            limit_reg        <= '0;
            issue_idx_reg    <= '0;
            pend_reg         <= 1'b0;
            found_reg        <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            valid_count_reg  <= valid_count_next;
            snap_reg         <= snap_next;
            limit_reg        <= limit_next;
            issue_idx_reg    <= issue_idx_next;
            pend_reg         <= pend_next;
            found_reg        <= found_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg       <= item_next;
        pend_idx_reg   <= pend_idx_next;
        first_idx_reg  <= first_idx_next;
        first_cost_reg <= first_cost_next;
        new_cost_reg   <= new_cost_next;
        new_hop_reg    <= new_hop_next;
        self_hop_reg   <= self_hop_next;
        wr_dest_reg    <= wr_dest_next;
        res_action_reg <= res_action_next;
        res_idx_reg    <= res_idx_next;
        res_cost_reg   <= res_cost_next;
        res_write_reg  <= res_write_next;
        res_append_reg <= res_append_next;
        result_reg     <= result_next;
    end

    assign route_stall  = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    assign tbl_raddr = issue_idx_reg[IDX_W-1:0];
    assign tbl_waddr = res_idx_reg;
    assign tbl_wdata = '{dest:     wr_dest_reg,
                         next_hop: new_hop_reg,
                         iface:    item_reg.recv_iface,
                         cost:     new_cost_reg};

endmodule

`default_nettype wire

/* src/distance_vector_table_update_core.sv */
// Distance-vector route table engine.
// Input channel route (route_valid / route_stall / route) carries one word per
// advertised route or direct install. Output channel result (result_valid /
// result_stall / result) returns exactly one word per input word, in order.
// The APB port writes the own-interface addresses and their count; configure
// only while the engine is idle. pready is always high.
// The result word is loaded after the search, once the output register is free.
// The search covers the entries valid at the start of the current message (at
// most TABLE_DEPTH), read one per cycle through the table's single read port.
// A deciding match ends the search early; an install searches nothing.
// route_stall is high from accept until the result is loaded, so the engine
// does not take a new word before it is through with the last one.
// If the receiver stalls, the result register holds its word; the engine still
// accepts the next word and completes its search, then waits with its table
// write until the output register frees.
// Reset empties the table by clearing the entry count and the message snapshot;
// the table memory itself is not cleared, and no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module distance_vector_table_update_core
    import dvtu_pkg::*;
#(
    parameter int TABLE_DEPTH    = 16,
    parameter int MAX_OWN_IFACES = 4
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              route_valid,
    output logic                   route_stall,
    input  wire route_word_t       route,
    output logic                   result_valid,
    input  wire logic              result_stall,
    output result_word_t           result,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    cfg_t             cfg;
    logic             tbl_we;
    logic [IDX_W-1:0] tbl_waddr;
    route_entry_t     tbl_wdata;
    logic             tbl_re;
    logic [IDX_W-1:0] tbl_raddr;
    route_entry_t     tbl_rdata;

    dvtu_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dvtu_table #(
        .DEPTH (TABLE_DEPTH),
        .IDX_W (IDX_W)
    ) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .re    (tbl_re),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    dvtu_engine #(
        .TABLE_DEPTH    (TABLE_DEPTH),
        .MAX_OWN_IFACES (MAX_OWN_IFACES),
        .IDX_W          (IDX_W),
        .CNT_W          (CNT_W)
    ) u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .route_valid  (route_valid),
        .route_stall  (route_stall),
        .route        (route),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .tbl_we       (tbl_we),
        .tbl_waddr    (tbl_waddr),
        .tbl_wdata    (tbl_wdata),
        .tbl_re       (tbl_re),
        .tbl_raddr    (tbl_raddr),
        .tbl_rdata    (tbl_rdata)
    );

endmodule

`default_nettype wire

/* src/dvtu_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module dvtu_checker
    import dvtu_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
)
(
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         route_valid,
    input wire logic         route_stall,
    input wire logic         result_valid,
    input wire logic         result_stall,
    input wire result_word_t result
);

    // A stalled result word stays in place.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result word changed or dropped");

    // One word at a time: the engine is busy right after an accept.
    assert property (@(posedge clk) disable iff (!rst_n)
        route_valid && !route_stall |=> route_stall)
        else $error("engine took a second word without working on the first");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.action <= ACT_FULL)
        else $error("result action code out of range");

    // A full table only reports when every entry is in use.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.action == ACT_FULL) |->
            (result.entry_index == 4'd0) && (result.entry_cost == 8'd0) &&
            (result.entry_count == 5'(TABLE_DEPTH)))
        else $error("table full reported with inconsistent fields");

    // An appended entry is always the last one in the table.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.action == ACT_APPENDED) |->
            result.entry_index == 4'(result.entry_count - 5'd1))
        else $error("appended entry index does not match entry count");

endmodule

bind distance_vector_table_update_core dvtu_checker #(
    .TABLE_DEPTH (TABLE_DEPTH)
) u_dvtu_checker (.*);

`default_nettype wire
